>>> rtl/core/crpe_pkg.sv
// Package for the command/poll/retry engine: item and result layouts,
// command, reply, action, error and phase codes, and a saturating counter helper.
// No dependencies.
`timescale 1ns / 1ps

package crpe_pkg;

	localparam int BTN_W      = 3;
	localparam int BTN_STATES_W = 12;
	localparam int MAX_ERR_W  = 8;
	localparam int TICKS_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 24;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_SUBMIT = 2'd1,
		CMD_REPLY  = 2'd2,
		CMD_NONE   = 2'd3
	} crpe_cmd_t;

	localparam logic [2:0] RPL_ACK      = 3'd0;
	localparam logic [2:0] RPL_NAK      = 3'd1;
	localparam logic [2:0] RPL_BUSY     = 3'd2;
	localparam logic [2:0] RPL_READY    = 3'd3;
	localparam logic [2:0] RPL_PRESSED  = 3'd4;
	localparam logic [2:0] RPL_RELEASED = 3'd5;

	localparam logic [2:0] ACT_NONE  = 3'd0;
	localparam logic [2:0] ACT_USER  = 3'd1;
	localparam logic [2:0] ACT_QUERY = 3'd2;
	localparam logic [2:0] ACT_READ  = 3'd3;
	localparam logic [2:0] ACT_ERROR = 3'd4;

	localparam logic [3:0] ERR_OK          = 4'd0;
	localparam logic [3:0] ERR_USR_NAK     = 4'd1;
	localparam logic [3:0] ERR_USR_READY   = 4'd2;
	localparam logic [3:0] ERR_USR_BUSY    = 4'd3;
	localparam logic [3:0] ERR_USR_UNKNOWN = 4'd4;
	localparam logic [3:0] ERR_USR_TIMEOUT = 4'd5;
	localparam logic [3:0] ERR_QRY_ACK     = 4'd6;
	localparam logic [3:0] ERR_QRY_NAK     = 4'd7;
	localparam logic [3:0] ERR_QRY_READY   = 4'd8;
	localparam logic [3:0] ERR_QRY_BUSY    = 4'd9;
	localparam logic [3:0] ERR_QRY_UNKNOWN = 4'd10;
	localparam logic [3:0] ERR_QRY_TIMEOUT = 4'd11;

	localparam logic [1:0] BS_UNKNOWN  = 2'd0;
	localparam logic [1:0] BS_RELEASED = 2'd1;
	localparam logic [1:0] BS_PRESSED  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ERRORS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLL_DELAY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd2;

	typedef enum logic [3:0] {
		PH_SEND  = 4'b0001,
		PH_POLL  = 4'b0010,
		PH_CHECK = 4'b0100,
		PH_ERROR = 4'b1000
	} crpe_phase_t;

	typedef struct packed {
		logic [BTN_W-1:0] reply_button;
		logic [2:0]       reply_class;
		logic [1:0]       command;
	} crpe_item_t;

	typedef struct packed {
		logic [BTN_STATES_W-1:0] button_states;
		logic [3:0]              error_code;
		logic                    cmd_taken;
		logic                    ready_res;
		logic [BTN_W-1:0]        query_button;
		logic [2:0]              action;
	} crpe_result_t;

	typedef struct packed {
		logic [MAX_ERR_W-1:0] max_errors;
		logic [TICKS_W-1:0]   poll_delay_ticks;
		logic [TICKS_W-1:0]   timeout_ticks;
	} crpe_cfg_t;

	function automatic logic [MAX_ERR_W-1:0] sat_inc(input logic [MAX_ERR_W-1:0] c);
		sat_inc = (c == '1) ? c : c + MAX_ERR_W'(1);
	endfunction

endpackage

>>> rtl/core/crpe_engine.sv
// Engine state registers and next-state logic: one item is applied per enabled cycle.
// Depends on crpe_pkg.
`timescale 1ns / 1ps

module crpe_engine #(
	parameter int NUM_BUTTONS = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  crpe_pkg::crpe_item_t item,
	input  crpe_pkg::crpe_cfg_t  cfg,
	output crpe_pkg::crpe_result_t res
);

	crpe_pkg::crpe_phase_t phase_q, phase_d;
	logic                             user_pend_q, user_pend_d;
	logic                             qry_pend_q, qry_pend_d;
	logic                             ready_q, ready_d;
	logic [crpe_pkg::TICKS_W-1:0]     timer_q, timer_d;
	logic [crpe_pkg::MAX_ERR_W-1:0]   ufail_q, ufail_d;
	logic [crpe_pkg::MAX_ERR_W-1:0]   qfail_q, qfail_d;
	logic [crpe_pkg::BTN_W-1:0]       qidx_q, qidx_d, qidx_inc;
	logic [1:0]                       store_q [NUM_BUTTONS];
	logic [1:0]                       store_d [NUM_BUTTONS];
	logic [3:0]                       err_q, err_d;
	logic [1:0]                       estep_q, estep_d;

	logic                             user_active, is_button, clr_query;
	logic [crpe_pkg::MAX_ERR_W-1:0]   fail_new;
	logic [2:0]                       act;
	logic [crpe_pkg::BTN_W-1:0]       qbtn;
	logic                             taken;
	logic [crpe_pkg::BTN_STATES_W-1:0] packed_bs;

	assign user_active = user_pend_q && !qry_pend_q;
	assign is_button = (item.reply_class == crpe_pkg::RPL_PRESSED
		|| item.reply_class == crpe_pkg::RPL_RELEASED)
		&& (item.reply_button < crpe_pkg::BTN_W'(NUM_BUTTONS));
	assign qidx_inc = qidx_q + crpe_pkg::BTN_W'(1);

	always_comb begin
		phase_d     = phase_q;
		user_pend_d = user_pend_q;
		qry_pend_d  = qry_pend_q;
		ready_d     = ready_q;
		timer_d     = timer_q;
		ufail_d     = ufail_q;
		qfail_d     = qfail_q;
		qidx_d      = qidx_q;
		err_d       = err_q;
		estep_d     = estep_q;
		store_d     = store_q;
		act         = crpe_pkg::ACT_NONE;
		qbtn        = '0;
		taken       = 1'b0;
		clr_query   = 1'b0;
		fail_new    = '0;

		unique case (item.command)
			crpe_pkg::CMD_TICK: begin
				unique case (phase_q)
					crpe_pkg::PH_SEND: begin
						if (user_active) begin
							act = crpe_pkg::ACT_USER;
						end else begin
							act  = crpe_pkg::ACT_QUERY;
							qbtn = qidx_q;
						end
						ready_d = 1'b0;
						timer_d = '0;
						phase_d = crpe_pkg::PH_POLL;
					end
					crpe_pkg::PH_POLL: begin
						if (timer_q >= cfg.poll_delay_ticks) begin
							timer_d = '0;
							phase_d = crpe_pkg::PH_CHECK;
							act     = crpe_pkg::ACT_READ;
						end else begin
							timer_d = timer_q + crpe_pkg::TICKS_W'(1);
						end
					end
					crpe_pkg::PH_CHECK: begin
						if (timer_q < cfg.timeout_ticks) begin
							timer_d = timer_q + crpe_pkg::TICKS_W'(1);
						end else if (user_active) begin
							fail_new = crpe_pkg::sat_inc(ufail_q);
							ufail_d  = fail_new;
							if (fail_new < cfg.max_errors) begin
								phase_d = crpe_pkg::PH_SEND;
							end else begin
								err_d   = crpe_pkg::ERR_USR_TIMEOUT;
								phase_d = crpe_pkg::PH_ERROR;
							end
						end else begin
							clr_query = 1'b1;
							fail_new  = crpe_pkg::sat_inc(qfail_q);
							qfail_d   = fail_new;
							if (fail_new < cfg.max_errors) begin
								phase_d = crpe_pkg::PH_SEND;
							end else begin
								err_d   = crpe_pkg::ERR_QRY_TIMEOUT;
								phase_d = crpe_pkg::PH_ERROR;
							end
						end
					end
					default: begin
						if (estep_q == 2'd0) begin
							estep_d = 2'd1;
						end else if (estep_q == 2'd1) begin
							estep_d = 2'd2;
							act     = crpe_pkg::ACT_ERROR;
						end
					end
				endcase
			end
			crpe_pkg::CMD_SUBMIT: begin
				if (ready_q) begin
					user_pend_d = 1'b1;
					taken       = 1'b1;
				end
			end
			crpe_pkg::CMD_REPLY: begin
				if (phase_q == crpe_pkg::PH_CHECK) begin
					if (user_active) begin
						if (item.reply_class == crpe_pkg::RPL_ACK) begin
							ufail_d     = '0;
							user_pend_d = 1'b0;
							qry_pend_d  = 1'b1;
							phase_d     = crpe_pkg::PH_SEND;
						end else begin
							fail_new = crpe_pkg::sat_inc(ufail_q);
							ufail_d  = fail_new;
							if (fail_new < cfg.max_errors) begin
								if (item.reply_class == crpe_pkg::RPL_BUSY) begin
									timer_d = '0;
									phase_d = crpe_pkg::PH_POLL;
								end else begin
									phase_d = crpe_pkg::PH_SEND;
								end
							end else begin
								phase_d = crpe_pkg::PH_ERROR;
								priority case (item.reply_class)
									crpe_pkg::RPL_NAK:   err_d = crpe_pkg::ERR_USR_NAK;
									crpe_pkg::RPL_READY: err_d = crpe_pkg::ERR_USR_READY;
									crpe_pkg::RPL_BUSY:  err_d = crpe_pkg::ERR_USR_BUSY;
									default:             err_d = crpe_pkg::ERR_USR_UNKNOWN;
								endcase
							end
						end
					end else if (is_button) begin
						for (int i = 0; i < NUM_BUTTONS; i++) begin
							if (item.reply_button == crpe_pkg::BTN_W'(i))
								store_d[i] = (item.reply_class == crpe_pkg::RPL_PRESSED)
									? crpe_pkg::BS_PRESSED : crpe_pkg::BS_RELEASED;
						end
						qfail_d = '0;
						if (qry_pend_q) begin
							qry_pend_d = 1'b0;
							ready_d    = 1'b1;
						end else if (!user_pend_q) begin
							ready_d = 1'b1;
						end
						qidx_d  = (qidx_inc >= crpe_pkg::BTN_W'(NUM_BUTTONS)) ? '0 : qidx_inc;
						phase_d = crpe_pkg::PH_SEND;
					end else begin
						clr_query = 1'b1;
						fail_new  = crpe_pkg::sat_inc(qfail_q);
						qfail_d   = fail_new;
						if (fail_new < cfg.max_errors) begin
							if (item.reply_class == crpe_pkg::RPL_BUSY) begin
								timer_d = '0;
								phase_d = crpe_pkg::PH_POLL;
							end else begin
								phase_d = crpe_pkg::PH_SEND;
							end
						end else begin
							phase_d = crpe_pkg::PH_ERROR;
							priority case (item.reply_class)
								crpe_pkg::RPL_ACK:   err_d = crpe_pkg::ERR_QRY_ACK;
								crpe_pkg::RPL_NAK:   err_d = crpe_pkg::ERR_QRY_NAK;
								crpe_pkg::RPL_READY: err_d = crpe_pkg::ERR_QRY_READY;
								crpe_pkg::RPL_BUSY:  err_d = crpe_pkg::ERR_QRY_BUSY;
								default:             err_d = crpe_pkg::ERR_QRY_UNKNOWN;
							endcase
						end
					end
				end
			end
			default: ;
		endcase

		// failed query marks the queried button unknown
		if (clr_query) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				if (qidx_q == crpe_pkg::BTN_W'(i))
					store_d[i] = crpe_pkg::BS_UNKNOWN;
			end
		end
	end

	always_comb begin
		packed_bs = '0;
		for (int i = 0; i < NUM_BUTTONS; i++)
			packed_bs[2*i +: 2] = store_d[i];
	end

	assign res.action        = act;
	assign res.query_button  = qbtn;
	assign res.ready_res     = ready_d;
	assign res.cmd_taken     = taken;
	assign res.error_code    = err_d;
	assign res.button_states = packed_bs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= crpe_pkg::PH_SEND;
			user_pend_q <= 1'b0;
			qry_pend_q  <= 1'b0;
			ready_q     <= 1'b1;
			timer_q     <= '0;
			ufail_q     <= '0;
			qfail_q     <= '0;
			qidx_q      <= '0;
			err_q       <= crpe_pkg::ERR_OK;
			estep_q     <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++)
				store_q[i] <= crpe_pkg::BS_UNKNOWN;
		end else if (step_en) begin
			phase_q     <= phase_d;
			user_pend_q <= user_pend_d;
			qry_pend_q  <= qry_pend_d;
			ready_q     <= ready_d;
			timer_q     <= timer_d;
			ufail_q     <= ufail_d;
			qfail_q     <= qfail_d;
			qidx_q      <= qidx_d;
			err_q       <= err_d;
			estep_q     <= estep_d;
			store_q     <= store_d;
		end
	end

endmodule

>>> rtl/core/crpe_out_reg.sv
// Result register of the engine: holds one result item until the sink takes it.
// Depends on crpe_pkg.
`timescale 1ns / 1ps

module crpe_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load_en,
	input  logic                  load_valid,
	input  crpe_pkg::crpe_result_t load_res,
	output logic                  out_valid,
	output crpe_pkg::crpe_result_t out_res
);

	logic                   valid_q;
	crpe_pkg::crpe_result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_en) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en && load_valid) begin
			res_q <= load_res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

>>> rtl/core/command_poll_retry_engine_core.sv
// Command/poll/retry engine for a module that answers with one status byte.
// Depends on crpe_pkg, crpe_engine and crpe_out_reg.
//
// One input item (tick, user submit or classified reply byte) is taken every clock cycle while
// s_axis_tready is high and gives exactly one result item, presented on the result port after
// it passes an input register, then the state update of the engine, then a result register.
// s_axis_tready falls only while both the input register and the result register are full
// and m_axis_tready is low. Configuration writes take effect on the next item.
`timescale 1ns / 1ps

module command_poll_retry_engine_core #(
	parameter int NUM_BUTTONS = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [crpe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [crpe_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// command [1:0], reply_class [4:2], reply_button [7:5]
	input  logic [crpe_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// action [2:0], query_button [5:3], ready_res [6], cmd_taken [7],
	// error_code [11:8], button_states [23:12]
	output logic [crpe_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	crpe_pkg::crpe_cfg_t    cfg_q;
	crpe_pkg::crpe_item_t   item_s1;
	logic                   valid_s1;
	logic                   adv;
	crpe_pkg::crpe_result_t step_res;
	crpe_pkg::crpe_result_t out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_errors       <= 8'd5;
			cfg_q.poll_delay_ticks <= 16'd5;
			cfg_q.timeout_ticks    <= 16'd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				crpe_pkg::REG_MAX_ERRORS:
					cfg_q.max_errors <= cfg_data[crpe_pkg::MAX_ERR_W-1:0];
				crpe_pkg::REG_POLL_DELAY: cfg_q.poll_delay_ticks <= cfg_data;
				crpe_pkg::REG_TIMEOUT:    cfg_q.timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= crpe_pkg::crpe_item_t'(s_axis_tdata);
		end
	end

	crpe_engine #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (valid_s1 && adv),
		.item    (item_s1),
		.cfg     (cfg_q),
		.res     (step_res)
	);

	crpe_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_en    (adv),
		.load_valid (valid_s1),
		.load_res   (step_res),
		.out_valid  (m_axis_tvalid),
		.out_res    (out_res)
	);

	assign m_axis_tdata = out_res;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && m_axis_tvalid && !m_axis_tready))
		else $error("input stalled while a stage was free");

	a_error_event_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_res.action == crpe_pkg::ACT_ERROR)
		|-> (out_res.error_code != crpe_pkg::ERR_OK))
		else $error("error event without a latched error code");

	a_taken_implies_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_res.cmd_taken) |-> (out_res.ready_res
		&& out_res.action == crpe_pkg::ACT_NONE))
		else $error("user command taken while not ready");

	a_result_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv) |=> m_axis_tvalid)
		else $error("engine step lost its result");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for command_poll_retry_engine_core: a scoreboard class tracks the
// engine's state per accepted item and checks every result; plain tasks drive the input stream.
// Depends on crpe_pkg and the RTL of command_poll_retry_engine_core.
`timescale 1ns / 1ps

module tb;

	localparam int N_BTN = 6;
	localparam int LIMIT = 400_000;
	localparam logic [2:0] RPL_OTHER = 3'd6;
	localparam logic [2:0] RPL_INVALID = 3'd7;
	localparam logic [crpe_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	class retry_tracker;
		logic [7:0] max_err;
		logic [15:0] poll_dly;
		logic [15:0] tmo;
		crpe_pkg::crpe_phase_t ph;
		bit usr_pend;
		bit qry_pend;
		bit rdy;
		logic [15:0] timer;
		logic [7:0] usr_fails;
		logic [7:0] qry_fails;
		logic [2:0] qidx;
		logic [1:0] btn_store [N_BTN];
		logic [3:0] err;
		logic [1:0] err_step;
		crpe_pkg::crpe_result_t pending_results [$];
		int errors;

		function new();
			max_err = 8'd5;
			poll_dly = 16'd5;
			tmo = 16'd100;
			ph = crpe_pkg::PH_SEND;
			usr_pend = 0;
			qry_pend = 0;
			rdy = 1;
			timer = '0;
			usr_fails = '0;
			qry_fails = '0;
			qidx = '0;
			foreach (btn_store[i]) btn_store[i] = crpe_pkg::BS_UNKNOWN;
			err = crpe_pkg::ERR_OK;
			err_step = '0;
			errors = 0;
		endfunction

		function void set_regs(logic [7:0] m, logic [15:0] p, logic [15:0] t);
			max_err = m;
			poll_dly = p;
			tmo = t;
		endfunction

		function bit user_active();
			return usr_pend && !qry_pend;
		endfunction

		function logic [7:0] sat_bump(logic [7:0] c);
			return c + {7'd0, c != 8'hFF};
		endfunction

		function bit is_button(crpe_pkg::crpe_item_t it);
			return (it.reply_class == crpe_pkg::RPL_PRESSED ||
				it.reply_class == crpe_pkg::RPL_RELEASED) &&
				it.reply_button < 3'(N_BTN);
		endfunction

		// bumps the fail counter of the transfer in flight; 1 when that latches an error
		function bit fail_latches();
			if (user_active()) begin
				usr_fails = sat_bump(usr_fails);
				return usr_fails >= max_err;
			end
			btn_store[qidx] = crpe_pkg::BS_UNKNOWN;
			qry_fails = sat_bump(qry_fails);
			return qry_fails >= max_err;
		endfunction

		// 1 when this item would make the engine latch an error
		function bit fatal_failure(crpe_pkg::crpe_item_t it);
			bit fails;
			logic [7:0] cnt;
			fails = 0;
			if (ph == crpe_pkg::PH_CHECK) begin
				if (it.command == crpe_pkg::CMD_TICK)
					fails = timer >= tmo;
				else if (it.command == crpe_pkg::CMD_REPLY)
					fails = user_active() ? it.reply_class != crpe_pkg::RPL_ACK :
						!is_button(it);
			end
			cnt = user_active() ? usr_fails : qry_fails;
			return fails && sat_bump(cnt) >= max_err;
		endfunction

		function void on_tick(output logic [2:0] act, output logic [2:0] qb);
			act = crpe_pkg::ACT_NONE;
			qb = '0;
			case (ph)
				crpe_pkg::PH_SEND: begin
					if (user_active()) begin
						act = crpe_pkg::ACT_USER;
					end else begin
						act = crpe_pkg::ACT_QUERY;
						qb = qidx;
					end
					rdy = 0;
					timer = '0;
					ph = crpe_pkg::PH_POLL;
				end
				crpe_pkg::PH_POLL: begin
					if (timer >= poll_dly) begin
						timer = '0;
						ph = crpe_pkg::PH_CHECK;
						act = crpe_pkg::ACT_READ;
					end else begin
						timer = timer + 16'd1;
					end
				end
				crpe_pkg::PH_CHECK: begin
					if (timer < tmo) begin
						timer = timer + 16'd1;
					end else if (!fail_latches()) begin
						ph = crpe_pkg::PH_SEND;
					end else begin
						err = user_active() ? crpe_pkg::ERR_USR_TIMEOUT :
							crpe_pkg::ERR_QRY_TIMEOUT;
						ph = crpe_pkg::PH_ERROR;
					end
				end
				default: begin
					if (err_step == 2'd0) begin
						err_step = 2'd1;
					end else if (err_step == 2'd1) begin
						err_step = 2'd2;
						act = crpe_pkg::ACT_ERROR;
					end
				end
			endcase
		endfunction

		function void on_reply(crpe_pkg::crpe_item_t it);
			bit user;
			user = user_active();
			if (user && it.reply_class == crpe_pkg::RPL_ACK) begin
				usr_fails = '0;
				usr_pend = 0;
				qry_pend = 1;
				ph = crpe_pkg::PH_SEND;
			end else if (!user && is_button(it)) begin
				btn_store[it.reply_button] = (it.reply_class == crpe_pkg::RPL_PRESSED) ?
					crpe_pkg::BS_PRESSED : crpe_pkg::BS_RELEASED;
				qry_fails = '0;
				if (qry_pend) begin
					qry_pend = 0;
					rdy = 1;
				end else if (!usr_pend) begin
					rdy = 1;
				end
				qidx = (qidx == 3'(N_BTN - 1)) ? 3'd0 : qidx + 3'd1;
				ph = crpe_pkg::PH_SEND;
			end else if (!fail_latches()) begin
				if (it.reply_class == crpe_pkg::RPL_BUSY) begin
					timer = '0;
					ph = crpe_pkg::PH_POLL;
				end else begin
					ph = crpe_pkg::PH_SEND;
				end
			end else begin
				if (user) begin
					case (it.reply_class)
						crpe_pkg::RPL_NAK: err = crpe_pkg::ERR_USR_NAK;
						crpe_pkg::RPL_READY: err = crpe_pkg::ERR_USR_READY;
						crpe_pkg::RPL_BUSY: err = crpe_pkg::ERR_USR_BUSY;
						default: err = crpe_pkg::ERR_USR_UNKNOWN;
					endcase
				end else begin
					case (it.reply_class)
						crpe_pkg::RPL_ACK: err = crpe_pkg::ERR_QRY_ACK;
						crpe_pkg::RPL_NAK: err = crpe_pkg::ERR_QRY_NAK;
						crpe_pkg::RPL_READY: err = crpe_pkg::ERR_QRY_READY;
						crpe_pkg::RPL_BUSY: err = crpe_pkg::ERR_QRY_BUSY;
						default: err = crpe_pkg::ERR_QRY_UNKNOWN;
					endcase
				end
				ph = crpe_pkg::PH_ERROR;
			end
		endfunction

		function void take_item(crpe_pkg::crpe_item_t it);
			crpe_pkg::crpe_result_t r;
			logic [2:0] act;
			logic [2:0] qb;
			bit taken;
			act = crpe_pkg::ACT_NONE;
			qb = '0;
			taken = 0;
			case (it.command)
				crpe_pkg::CMD_TICK: on_tick(act, qb);
				crpe_pkg::CMD_SUBMIT: begin
					if (rdy) begin
						usr_pend = 1;
						taken = 1;
					end
				end
				crpe_pkg::CMD_REPLY: if (ph == crpe_pkg::PH_CHECK) on_reply(it);
				default: ;
			endcase
			r = '0;
			r.action = act;
			r.query_button = qb;
			r.ready_res = rdy;
			r.cmd_taken = taken;
			r.error_code = err;
			foreach (btn_store[i]) r.button_states[2 * i +: 2] = btn_store[i];
			pending_results.push_back(r);
		endfunction

		function int field_bad(string name, logic [11:0] want, logic [11:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				return 1;
			end
			return 0;
		endfunction

		function void match_result(crpe_pkg::crpe_result_t got);
			crpe_pkg::crpe_result_t want;
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: %h", got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			errors += field_bad("action", 12'(want.action), 12'(got.action));
			errors += field_bad("query_button", 12'(want.query_button), 12'(got.query_button));
			errors += field_bad("ready_res", 12'(want.ready_res), 12'(got.ready_res));
			errors += field_bad("cmd_taken", 12'(want.cmd_taken), 12'(got.cmd_taken));
			errors += field_bad("error_code", 12'(want.error_code), 12'(got.error_code));
			errors += field_bad("button_states", want.button_states, got.button_states);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;

	retry_tracker sb = new();
	int burst_left = 0;
	int cycles = 0;
	int rx_mode = 0;
	int rx_left = 0;
	int rx_beat = 0;

	command_poll_retry_engine_core #(.NUM_BUTTONS(N_BTN)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: checks, then drives m_axis_tready in one of four modes that are picked anew at random
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.match_result(m_axis_tdata);
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 300);
		end
		rx_left--;
		rx_beat++;
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= $urandom_range(0, 9) < 7;
			2: m_axis_tready <= (rx_beat % 4) != 0;
			default: m_axis_tready <= (rx_beat % 24) < 12;
		endcase
	end

	task automatic send_item(crpe_pkg::crpe_item_t it);
		int gap;
		s_axis_tdata <= it;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.take_item(it);
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) :
				$urandom_range(1, 32);
			gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send(logic [1:0] cmd, logic [2:0] cls = crpe_pkg::RPL_ACK,
		logic [2:0] b = 3'd0);
		crpe_pkg::crpe_item_t it;
		it.command = cmd;
		it.reply_class = cls;
		it.reply_button = b;
		send_item(it);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending_results.size() != 0);
	endtask

	task automatic set_config(logic [7:0] m, logic [15:0] p, logic [15:0] t);
		cfg_we <= 1'b1;
		cfg_index <= crpe_pkg::REG_MAX_ERRORS;
		cfg_data <= {8'($urandom()), m};
		@(posedge clk);
		cfg_index <= crpe_pkg::REG_POLL_DELAY;
		cfg_data <= p;
		@(posedge clk);
		cfg_index <= crpe_pkg::REG_TIMEOUT;
		cfg_data <= t;
		@(posedge clk);
		cfg_index <= REG_UNUSED;
		cfg_data <= 16'($urandom());
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_regs(m, p, t);
	endtask

	// mostly well-formed transfers; keep_alive swaps any item that would latch an error
	function automatic crpe_pkg::crpe_item_t next_item(bit keep_alive);
		crpe_pkg::crpe_item_t it;
		int roll;
		roll = $urandom_range(0, 99);
		it = 8'($urandom());
		if (roll >= 10) begin
			it.reply_button = 3'($urandom_range(0, N_BTN - 1));
			case (sb.ph)
				crpe_pkg::PH_SEND:
					it.command = (sb.rdy && roll < 40) ? crpe_pkg::CMD_SUBMIT :
						crpe_pkg::CMD_TICK;
				crpe_pkg::PH_POLL:
					it.command = (roll < 14) ? crpe_pkg::CMD_SUBMIT : crpe_pkg::CMD_TICK;
				crpe_pkg::PH_CHECK: begin
					if (roll < 35) begin
						it.command = crpe_pkg::CMD_TICK;
					end else begin
						it.command = crpe_pkg::CMD_REPLY;
						if (roll >= 80) begin
							it.reply_class = 3'($urandom());
							it.reply_button = 3'($urandom());
						end else if (sb.user_active()) begin
							it.reply_class = crpe_pkg::RPL_ACK;
						end else begin
							it.reply_class = roll[0] ? crpe_pkg::RPL_PRESSED :
								crpe_pkg::RPL_RELEASED;
						end
					end
				end
				default: it.command = 2'($urandom());
			endcase
		end
		if (keep_alive && sb.fatal_failure(it)) begin
			it.command = crpe_pkg::CMD_REPLY;
			it.reply_class = sb.user_active() ? crpe_pkg::RPL_ACK : crpe_pkg::RPL_PRESSED;
			it.reply_button = 3'($urandom_range(0, N_BTN - 1));
		end
		return it;
	endfunction

	task automatic run_phase(logic [7:0] m, logic [15:0] p, logic [15:0] t, int n);
		set_config(m, p, t);
		repeat (n) begin
			send_item(next_item(1));
			if ($urandom_range(0, 199) == 0) drain();
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values first: poll delay of 5
		send(crpe_pkg::CMD_SUBMIT);
		send(crpe_pkg::CMD_SUBMIT);
		send(crpe_pkg::CMD_REPLY, crpe_pkg::RPL_ACK);
		send(crpe_pkg::CMD_NONE, RPL_INVALID, 3'd7);
		send(crpe_pkg::CMD_TICK);
		send(crpe_pkg::CMD_REPLY, crpe_pkg::RPL_NAK);
		while (sb.ph == crpe_pkg::PH_POLL) send(crpe_pkg::CMD_TICK);
		drain();

		set_config(8'd5, 16'd0, 16'd2);
		send(crpe_pkg::CMD_TICK);
		send(crpe_pkg::CMD_REPLY, crpe_pkg::RPL_BUSY);
		send(crpe_pkg::CMD_TICK);
		send(crpe_pkg::CMD_REPLY, crpe_pkg::RPL_READY);
		send(crpe_pkg::CMD_TICK);
		send(crpe_pkg::CMD_TICK);
		send(crpe_pkg::CMD_REPLY, crpe_pkg::RPL_ACK);
		send(crpe_pkg::CMD_SUBMIT);
		send(crpe_pkg::CMD_TICK);
		send(crpe_pkg::CMD_TICK);
		send(crpe_pkg::CMD_REPLY, crpe_pkg::RPL_PRESSED, 3'd3);
		send(crpe_pkg::CMD_TICK);
		send(crpe_pkg::CMD_TICK);
		send(crpe_pkg::CMD_REPLY, RPL_INVALID, 3'd7);
		send(crpe_pkg::CMD_TICK);
		send(crpe_pkg::CMD_TICK);
		send(crpe_pkg::CMD_REPLY, crpe_pkg::RPL_PRESSED, 3'(N_BTN));
		send(crpe_pkg::CMD_TICK);
		send(crpe_pkg::CMD_TICK);
		repeat (3) send(crpe_pkg::CMD_TICK);
		send(crpe_pkg::CMD_TICK);
		send(crpe_pkg::CMD_TICK);
		send(crpe_pkg::CMD_REPLY, crpe_pkg::RPL_RELEASED, 3'd1);
		send(crpe_pkg::CMD_TICK);
		send(crpe_pkg::CMD_TICK);
		send(crpe_pkg::CMD_REPLY, RPL_OTHER, 3'd2);
		drain();

		run_phase(8'd5, 16'd0, 16'd0, 220);
		run_phase(8'd1, 16'd3, 16'd10, 220);
		run_phase(8'd255, 16'd0, 16'd1, 220);

		// long waits: one poll delay and one timeout well above the random phases
		set_config(8'd255, 16'd40, 16'd60);
		if (sb.rdy) send(crpe_pkg::CMD_SUBMIT);
		send(crpe_pkg::CMD_TICK);
		while (sb.ph != crpe_pkg::PH_SEND) send(crpe_pkg::CMD_TICK);
		drain();

		run_phase(8'd2, 16'd1, 16'd3, 220);
		run_phase(8'd3, 16'd2, 16'd5, 160);

		// zero error budget: the first failure latches, then the engine stays stopped
		set_config(8'd0, 16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)));
		while (sb.ph != crpe_pkg::PH_ERROR) send_item(next_item(0));
		repeat (3) send(crpe_pkg::CMD_TICK);
		repeat (30) send_item(next_item(0));
		drain();

		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

>>> command_poll_retry_engine_core.f
rtl/core/crpe_pkg.sv
rtl/core/crpe_engine.sv
rtl/core/crpe_out_reg.sv
rtl/core/command_poll_retry_engine_core.sv
tb/sv/tb.sv
